@@ design/les_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Largest empty square finder: shared package
// Widths, limits, register indexes and reset values used across the block.
// ----------------------------------------------------------------------------
package les_pkg;

  // map limits
  localparam int unsigned MaxCols = 1024;
  localparam int unsigned MaxRows = 1024;

  // field widths
  localparam int unsigned ColW     = $clog2(MaxCols);
  localparam int unsigned RowW     = $clog2(MaxRows);
  localparam int unsigned SizeW    = 11;
  localparam int unsigned CntW     = 11;
  localparam int unsigned CharW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned OutDataW = 32;

  // printable marker range
  localparam logic [CharW-1:0] PrintLo = 8'd32;
  localparam logic [CharW-1:0] PrintHi = 8'd126;

  // register reset values
  localparam logic [CntW-1:0]  RstMapRows  = 11'd1;
  localparam logic [CntW-1:0]  RstMapCols  = 11'd1;
  localparam logic [CharW-1:0] RstEmptyCh  = 8'd46;
  localparam logic [CharW-1:0] RstObstCh   = 8'd111;
  localparam logic [CharW-1:0] RstFullCh   = 8'd120;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMapRows  = 3'd0,
    CfgMapCols  = 3'd1,
    CfgEmptyCh  = 3'd2,
    CfgObstCh   = 3'd3,
    CfgFullCh   = 3'd4
  } cfg_reg_e;

  // line shift control between top level and the cell chain
  typedef struct packed {
    logic            shift;
    logic [ColW-1:0] ins_idx;
  } line_ctrl_t;

endpackage

@@ design/les_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line cell
// Holds one square size; takes the neighbor's value on a shift, or the new
// size when it is the insertion point.
// ----------------------------------------------------------------------------
module les_cell (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic                          load_i,
  input  logic [les_pkg::SizeW-1:0]     nbr_i,
  input  logic [les_pkg::SizeW-1:0]     new_i,
  output logic [les_pkg::SizeW-1:0]     size_o
);

  logic [les_pkg::SizeW-1:0] size_q, size_d;

  // next value: new size at the insertion point, else the neighbor's
  always_comb begin
    size_d = size_q;
    if (shift_i) begin
      size_d = load_i ? new_i : nbr_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    size_q <= size_d;
  end

  assign size_o = size_q;

endmodule

@@ design/les_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line chain
// Row of size cells acting as a variable-length delay line: new sizes enter
// at cell (cols - 1) and move toward cell 0, where the size from one row
// above is read.
// ----------------------------------------------------------------------------
module les_chain (
  input  logic                          clk_i,
  input  les_pkg::line_ctrl_t           ctrl_i,
  input  logic [les_pkg::SizeW-1:0]     new_i,
  output logic [les_pkg::SizeW-1:0]     up_o
);

  logic [les_pkg::SizeW-1:0] size_w [les_pkg::MaxCols];

  // cells, each fed by its upper neighbor; the top cell holds itself
  for (genvar i = 0; i < les_pkg::MaxCols; i++) begin : g_cell
    logic [les_pkg::SizeW-1:0] nbr_w;
    logic                      load_w;

    if (i == les_pkg::MaxCols - 1) begin : g_top
      assign nbr_w = size_w[i];
    end else begin : g_mid
      assign nbr_w = size_w[i+1];
    end

    assign load_w = (ctrl_i.ins_idx == les_pkg::ColW'(i));

    les_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl_i.shift),
      .load_i  (load_w),
      .nbr_i   (nbr_w),
      .new_i   (new_i),
      .size_o  (size_w[i])
    );
  end

  assign up_o = size_w[0];

endmodule

@@ design/largest_empty_square_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Largest empty square finder
// Streams map cells in raster order and reports the first largest empty
// square of each map.
// ----------------------------------------------------------------------------
// Takes one map cell per clock cycle, back to back, and after the last cell
// of a map (map_rows x map_cols cells) presents one result item in the
// cycle after that cell is accepted. The size of the square ending at each
// cell is computed in the accepting cycle from the left and diagonal
// registers and from the size one row above, which comes out of a chain of
// 1024 cells that shifts once per item; that combinational path sets the rate.
// The result sits in an output register, so cells keep flowing while it waits;
// the input stalls only when the last cell of the next map arrives while the
// previous result has not been taken. No clearing pass is needed after reset.
// Configuration must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module largest_empty_square_finder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [les_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [les_pkg::CfgDataW-1:0]    cfg_data_i,
  // cell input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [les_pkg::CharW-1:0]       s_axis_tdata,   // [7:0] cell_char
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [10:0] square_size, [20:11] square_row, [30:21] square_col, [31] zero
  output logic [les_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tuser    // map_error
);

  localparam int unsigned SizeW = les_pkg::SizeW;
  localparam int unsigned ColW  = les_pkg::ColW;
  localparam int unsigned RowW  = les_pkg::RowW;
  localparam int unsigned CntW  = les_pkg::CntW;
  localparam int unsigned CharW = les_pkg::CharW;

  // configuration registers
  logic [CntW-1:0]  map_rows_q, map_cols_q;
  logic [CharW-1:0] empty_ch_q, obst_ch_q, full_ch_q;

  // scan state
  logic [SizeW-1:0] left_q, diag_q, best_size_q;
  logic [RowW-1:0]  row_q, best_row_q;
  logic [ColW-1:0]  col_q, best_col_q;
  logic             err_q;

  // output register
  logic                         m_valid_q;
  logic [les_pkg::OutDataW-1:0] m_data_q;
  logic                         m_user_q;

  logic [CntW-1:0]  rows_eff, cols_eff;
  logic             row_end, map_end, accept;
  logic [CharW-1:0] cell_ch;
  logic             unknown, obstacle, first_cell, better;
  logic [SizeW-1:0] up, min_ud, min3, size_new;
  logic [SizeW-1:0] nb_size, row_tmp, col_tmp;
  logic [RowW-1:0]  nb_row;
  logic [ColW-1:0]  nb_col;
  logic             marker_bad, err_out;
  les_pkg::line_ctrl_t line_ctrl;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_rows_q <= les_pkg::RstMapRows;
      map_cols_q <= les_pkg::RstMapCols;
      empty_ch_q <= les_pkg::RstEmptyCh;
      obst_ch_q  <= les_pkg::RstObstCh;
      full_ch_q  <= les_pkg::RstFullCh;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        les_pkg::CfgMapRows: map_rows_q <= cfg_data_i[CntW-1:0];
        les_pkg::CfgMapCols: map_cols_q <= cfg_data_i[CntW-1:0];
        les_pkg::CfgEmptyCh: empty_ch_q <= cfg_data_i[CharW-1:0];
        les_pkg::CfgObstCh:  obst_ch_q  <= cfg_data_i[CharW-1:0];
        les_pkg::CfgFullCh:  full_ch_q  <= cfg_data_i[CharW-1:0];
        default: ;
      endcase
    end
  end

  // effective counts: zero acts as one, large values saturate
  always_comb begin
    rows_eff = map_rows_q;
    if (map_rows_q == '0) begin
      rows_eff = CntW'(1);
    end else if (map_rows_q > CntW'(les_pkg::MaxRows)) begin
      rows_eff = CntW'(les_pkg::MaxRows);
    end
    cols_eff = map_cols_q;
    if (map_cols_q == '0) begin
      cols_eff = CntW'(1);
    end else if (map_cols_q > CntW'(les_pkg::MaxCols)) begin
      cols_eff = CntW'(les_pkg::MaxCols);
    end
  end

  // row and map end, from counters only
  assign row_end = (CntW'(col_q) + CntW'(1)) >= cols_eff;
  assign map_end = row_end && ((CntW'(row_q) + CntW'(1)) >= rows_eff);

  // hold input only when a result would land on a full output register
  assign s_axis_tready = !map_end || !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // cell classification; full is mapped to empty before the obstacle test
  assign cell_ch  = s_axis_tdata;
  assign unknown  = (cell_ch != empty_ch_q) && (cell_ch != obst_ch_q) &&
                    (cell_ch != full_ch_q);
  assign obstacle = unknown ||
                    ((cell_ch == full_ch_q) ? (empty_ch_q == obst_ch_q)
                                            : (cell_ch == obst_ch_q));

  // square size at this cell
  assign first_cell = (row_q == '0) || (col_q == '0);
  assign min_ud     = (up < diag_q) ? up : diag_q;
  assign min3       = (min_ud < left_q) ? min_ud : left_q;

  always_comb begin
    if (obstacle) begin
      size_new = '0;
    end else if (first_cell) begin
      size_new = SizeW'(1);
    end else begin
      size_new = min3 + SizeW'(1);
    end
  end

  // best square, first strictly larger wins
  assign better  = size_new > best_size_q;
  assign row_tmp = SizeW'(row_q) + SizeW'(1) - size_new;
  assign col_tmp = SizeW'(col_q) + SizeW'(1) - size_new;
  assign nb_size = better ? size_new : best_size_q;
  assign nb_row  = better ? row_tmp[RowW-1:0] : best_row_q;
  assign nb_col  = better ? col_tmp[ColW-1:0] : best_col_q;

  // marker set check
  assign marker_bad = (empty_ch_q == obst_ch_q) || (empty_ch_q == full_ch_q) ||
                      (obst_ch_q == full_ch_q) ||
                      (empty_ch_q < les_pkg::PrintLo) ||
                      (empty_ch_q > les_pkg::PrintHi) ||
                      (obst_ch_q < les_pkg::PrintLo) ||
                      (obst_ch_q > les_pkg::PrintHi) ||
                      (full_ch_q < les_pkg::PrintLo) ||
                      (full_ch_q > les_pkg::PrintHi);
  assign err_out = err_q || unknown || marker_bad ||
                   (map_rows_q == '0) || (map_cols_q == '0);

  // line of sizes from the row above
  assign line_ctrl.shift   = accept;
  assign line_ctrl.ins_idx = ColW'(cols_eff - CntW'(1));

  les_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (line_ctrl),
    .new_i  (size_new),
    .up_o   (up)
  );

  // scan state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      err_q       <= 1'b0;
    end else if (accept) begin
      if (map_end) begin
        left_q      <= '0;
        diag_q      <= '0;
        row_q       <= '0;
        col_q       <= '0;
        best_size_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
        err_q       <= 1'b0;
      end else begin
        best_size_q <= nb_size;
        best_row_q  <= nb_row;
        best_col_q  <= nb_col;
        err_q       <= err_q || unknown;
        if (row_end) begin
          left_q <= '0;
          diag_q <= '0;
          col_q  <= '0;
          row_q  <= row_q + RowW'(1);
        end else begin
          left_q <= size_new;
          diag_q <= up;
          col_q  <= col_q + ColW'(1);
        end
      end
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept && map_end) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept && map_end) begin
      m_data_q <= {1'b0, nb_col, nb_row, nb_size};
      m_user_q <= err_out;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
  // at the start of a row the neighbor sizes are clear
  a_row_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q == '0) |-> (left_q == '0 && diag_q == '0))
    else $error("left/diag not clear at row start");

  // a new result never lands on a pending one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && map_end) |-> (!m_valid_q || m_axis_tready))
    else $error("result overwrites pending output");

  // a map end restarts the scan
  a_scan_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && map_end) |=> (row_q == '0 && col_q == '0 &&
                             best_size_q == '0 && !err_q && m_valid_q))
    else $error("scan not restarted after map end");

  // no square means no position
  a_best_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_size_q == '0) |-> (best_row_q == '0 && best_col_q == '0))
    else $error("best position set without a square");
`endif

endmodule
